### sv/prime_count_in_range_defines.svh
// ---------------------------------------------------------------------------
// prime_count_in_range_defines.svh
// Assertion macros for the prime counter top level
// ---------------------------------------------------------------------------
`ifndef PRIME_COUNT_IN_RANGE_DEFINES_SVH
`define PRIME_COUNT_IN_RANGE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCIR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled during reset
`define PCIR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/pcir_pkg.sv
// ---------------------------------------------------------------------------
// pcir_pkg
// Shared types and constants of the prime counter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcir_pkg;

  // fixed widths of the channel fields
  localparam int FIELD_W = 16;
  localparam int CNT_W   = 16;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CAND,
    S_TEST,
    S_DIV,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // capture range, clear count
    logic div_init;    // first divisor two, square four
    logic div_start;   // launch remainder of candidate by divisor
    logic div_next;    // step to next divisor
    logic cand_next;   // step to next candidate
    logic count_inc;   // current candidate is prime
    logic result_load; // move count into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cand_done;   // candidate reached range end
    logic cand_small;  // candidate is zero or one
    logic sq_gt;       // divisor squared exceeds candidate
    logic div_busy;    // remainder unit running
    logic div_done;    // remainder ready this cycle
    logic rem_zero;    // remainder is zero
    logic out_free;    // output register can take a result
  } status_t;

endpackage

### sv/pcir_in_if.sv
// ---------------------------------------------------------------------------
// pcir_in_if
// Range request channel: valid/ready with start and end of the range
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcir_in_if import pcir_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] range_start;
  logic [FIELD_W-1:0] range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

### sv/pcir_out_if.sv
// ---------------------------------------------------------------------------
// pcir_out_if
// Count response channel: valid/ready with the prime count
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcir_out_if import pcir_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

### sv/pcir_rem.sv
// ---------------------------------------------------------------------------
// pcir_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcir_rem #(
  parameter int OP_W = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] dividend,
  input  logic [OP_W-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic            rem_zero
);

  localparam int CW = (OP_W > 1) ? $clog2(OP_W) : 1;

  logic [CW-1:0]   cnt;
  logic [OP_W-1:0] rem;
  logic [OP_W-1:0] dvd;
  logic [OP_W-1:0] dsr;
  logic [OP_W:0]   trial;
  logic [OP_W:0]   diff;
  logic [OP_W-1:0] rem_next;

  // shift in next dividend bit and conditionally subtract
  always_comb begin
    trial = {rem, dvd[OP_W-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = diff[OP_W-1:0];
    end else begin
      rem_next = trial[OP_W-1:0];
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && (cnt == CW'(OP_W - 1))) begin
      busy <= 1'b0;
      done <= 1'b1;
    end else begin
      done <= 1'b0;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      rem <= rem_next;
      dvd <= {dvd[OP_W-2:0], 1'b0};
    end
  end

  assign rem_zero = (rem == '0);

endmodule

### sv/pcir_dp.sv
// ---------------------------------------------------------------------------
// pcir_dp
// Datapath: candidate, divisor, running square, count and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcir_dp import pcir_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [FIELD_W-1:0] range_start,
  input  logic [FIELD_W-1:0] range_end,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [CNT_W-1:0]   prime_count
);

  localparam int OP_W = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int SQ_W = 2 * OP_W;

  logic [OP_W-1:0]  cand;
  logic [OP_W-1:0]  limit;
  logic [OP_W-1:0]  div;
  logic [SQ_W-1:0]  sq;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] result;
  logic             out_valid;
  logic             div_busy;
  logic             div_done;
  logic             rem_zero;

  // candidate walk and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand  <= range_start[OP_W-1:0];
      limit <= range_end[OP_W-1:0];
      count <= '0;
    end else begin
      if (cmd.cand_next) begin
        cand <= cand + OP_W'(1);
      end
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // divisor and its square, (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div <= OP_W'(2);
      sq  <= SQ_W'(4);
    end else if (cmd.div_next) begin
      div <= div + OP_W'(1);
      sq  <= sq + SQ_W'({div, 1'b1});
    end
  end

  pcir_rem #(
    .OP_W (OP_W)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cand),
    .divisor  (div),
    .busy     (div_busy),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      result <= count;
    end
  end

  assign rsp_valid   = out_valid;
  assign prime_count = result;

  // status toward the controller
  always_comb begin
    status.cand_done  = (cand >= limit);
    status.cand_small = (cand < OP_W'(2));
    status.sq_gt      = (sq > SQ_W'(cand));
    status.div_busy   = div_busy;
    status.div_done   = div_done;
    status.rem_zero   = rem_zero;
    status.out_free   = !out_valid || rsp_ready;
  end

endmodule

### sv/pcir_ctrl.sv
// ---------------------------------------------------------------------------
// pcir_ctrl
// Controller: walks candidates and divisors, sequences the remainder unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcir_ctrl import pcir_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CAND;
      end
      S_CAND: begin
        if (status.cand_done) begin
          state_next = S_FINISH;
        end else if (!status.cand_small) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (!status.sq_gt) state_next = S_DIV;
        else state_next = S_CAND;
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) state_next = S_CAND;
          else state_next = S_TEST;
        end
      end
      S_FINISH: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_CAND: begin
        // zero and one are skipped, others start at divisor two
        if (!status.cand_done) begin
          if (status.cand_small) cmd.cand_next = 1'b1;
          else cmd.div_init = 1'b1;
        end
      end
      S_TEST: begin
        // no divisor up to the square root: prime
        if (status.sq_gt) begin
          cmd.count_inc = 1'b1;
          cmd.cand_next = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          if (status.rem_zero) cmd.cand_next = 1'b1;
          else cmd.div_next = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.result_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### sv/prime_count_in_range.sv
// ---------------------------------------------------------------------------
// prime_count_in_range
// Counts primes in a half-open range by trial division
// ---------------------------------------------------------------------------
// channel  dir  handshake    payload
// req      in   valid/ready  range_start[15:0], range_end[15:0]
// rsp      out  valid/ready  prime_count[15:0]
//
// one range at a time; W = min(VALUE_WIDTH, 16)
// each candidate of two or more is tried against divisors from two up, each
//   divisor taking a test step and a run of the bit-serial remainder unit,
//   until one divides it or its square exceeds the candidate
// a finished count stalls while the previous one is unread; a result waits
//   in the output register while the next range is taken
// reset is synchronous and clears the controller state and the valid, busy and done flags only
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prime_count_in_range_defines.svh"

module prime_count_in_range import pcir_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  pcir_in_if.sink  req,
  pcir_out_if.source rsp
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  pcir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  pcir_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .range_start (req.range_start),
    .range_end   (req.range_end),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .prime_count (rsp.prime_count)
  );

  // checks
  `PCIR_ASSERT_NOW(a_accept_div_idle, req.valid && req.ready, !status.div_busy, "accept while busy")
  `PCIR_ASSERT_NOW(a_no_restart, cmd.div_start, !status.div_busy, "remainder restarted while busy")
  `PCIR_ASSERT_NOW(a_no_overwrite, cmd.result_load, !rsp.valid || rsp.ready, "result overwritten")
  `PCIR_ASSERT_NEXT(a_result_shown, cmd.result_load, rsp.valid, "loaded result not presented")

endmodule

### dv/prime_count_in_range_test.sv
// ---------------------------------------------------------------------------
// prime_count_in_range_test
// Self-checking bench for the trial-division prime counter. Range requests go
// in over the request channel; each accepted request is scored with a local
// prime count, and every count that comes back is compared in order. Directed
// ranges cover empty and reversed ranges, zero and one, squares of primes and
// the top of the 16-bit space. A long output stall is followed by random
// ranges under three idle patterns on the two channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_count_in_range_test;
  import pcir_pkg::*;

  localparam int VALUE_WIDTH   = 16;
  localparam int OPERAND_W     = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
  localparam int STALL_LIMIT   = 500000;
  localparam int TAIL_CYCLES   = 100;
  localparam int RANDOM_PHASE  = 25;
  localparam int FIELD_MAX     = (1 << FIELD_W) - 1;

  logic clk;
  logic rst;

  pcir_in_if  req_if ();
  pcir_out_if rsp_if ();

  prime_count_in_range #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // counts owed by the block, oldest first
  logic [CNT_W-1:0] expected_counts[$];

  int failures;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_cycles;
  int stall_cycles;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // number of primes n with lo <= n < hi, operands cut to the datapath width
  function automatic logic [CNT_W-1:0] count_primes_between(
    input logic [FIELD_W-1:0] lo_in,
    input logic [FIELD_W-1:0] hi_in
  );
    int unsigned lo;
    int unsigned hi;
    int unsigned n;
    int unsigned d;
    int unsigned total;
    bit          composite;
    lo    = lo_in & ((1 << OPERAND_W) - 1);
    hi    = hi_in & ((1 << OPERAND_W) - 1);
    total = 0;
    for (n = lo; n < hi; n++) begin
      if (n >= 2) begin
        composite = 1'b0;
        for (d = 2; d * d <= n && !composite; d++) begin
          if (n % d == 0) composite = 1'b1;
        end
        if (!composite) total++;
      end
    end
    return total[CNT_W-1:0];
  endfunction

  // offer one range, score it once the block takes it
  task automatic send_range(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.range_start <= lo;
    req_if.range_end   <= hi;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_counts.push_back(count_primes_between(lo, hi));
    @(negedge clk);
  endtask

  // stop offering and wait for every owed count
  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly short spans anywhere in the space, some reversed, some wider near zero or near the top
  task automatic pick_range(output logic [FIELD_W-1:0] lo, output logic [FIELD_W-1:0] hi);
    int unsigned sel;
    int unsigned base;
    int unsigned span;
    int unsigned top;
    sel = $urandom_range(99);
    if (sel < 10) begin
      base = $urandom_range(FIELD_MAX);
      top  = $urandom_range(base);
    end else begin
      if (sel < 25) begin
        base = $urandom_range(300);
        span = $urandom_range(60);
      end else if (sel < 30) begin
        base = $urandom_range(FIELD_MAX, FIELD_MAX - 135);
        span = $urandom_range(40);
      end else begin
        base = $urandom_range(FIELD_MAX);
        span = $urandom_range(12);
      end
      top = (base + span > FIELD_MAX) ? FIELD_MAX : base + span;
    end
    lo = base[FIELD_W-1:0];
    hi = top[FIELD_W-1:0];
  endtask

  // response side: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      rsp_if.ready <= 1'b0;
      recv_hold_cycles = recv_hold_cycles - 1;
    end else begin
      rsp_if.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each returned count with the oldest one owed
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_counts.size() == 0) begin
        $error("prime_count: unexpected transaction, value %0d", rsp_if.prime_count);
        failures++;
      end else begin
        if (rsp_if.prime_count !== expected_counts[0]) begin
          $error("prime_count mismatch: expected %0d, actual %0d",
                 expected_counts[0], rsp_if.prime_count);
          failures++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // empty and reversed ranges give zero
  task automatic test_empty_and_reversed();
    send_range(16'd0, 16'd0);
    send_range(16'd65535, 16'd65535);
    send_range(16'd65535, 16'd0);
    send_range(16'd100, 16'd50);
    send_range(16'd7, 16'd7);
    wait_results_drained();
  endtask

  // zero and one are not prime, two and three are
  task automatic test_small_values();
    send_range(16'd0, 16'd1);
    send_range(16'd0, 16'd2);
    send_range(16'd0, 16'd3);
    send_range(16'd1, 16'd2);
    send_range(16'd2, 16'd3);
    send_range(16'd2, 16'd4);
    wait_results_drained();
  endtask

  // squares of primes, whose last divisor tried is the root, and of 255
  task automatic test_prime_squares();
    send_range(16'd4, 16'd5);
    send_range(16'd9, 16'd10);
    send_range(16'd25, 16'd26);
    send_range(16'd63001, 16'd63002);
    send_range(16'd65025, 16'd65026);
    wait_results_drained();
  endtask

  // top of the space, a wide range from zero, top bit set
  task automatic test_field_extremes();
    send_range(16'd65521, 16'd65522);
    send_range(16'd65500, 16'd65535);
    send_range(16'd0, 16'd1000);
    send_range(16'd32768, 16'd32800);
    wait_results_drained();
  endtask

  // hold the response side off long enough for the block to stall its input
  task automatic test_output_backpressure();
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    recv_hold_cycles = 8000;
    for (int i = 0; i < 6; i++) begin
      lo = FIELD_W'($urandom_range(200));
      hi = lo + FIELD_W'($urandom_range(20));
      send_range(lo, hi);
    end
    wait_results_drained();
  endtask

  // random ranges under one idle pattern
  task automatic test_random_ranges(input int send_pct, input int recv_pct);
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < RANDOM_PHASE; i++) begin
      pick_range(lo, hi);
      send_range(lo, hi);
    end
    wait_results_drained();
  endtask

  initial begin
    failures           = 0;
    recv_hold_cycles   = 0;
    stall_cycles       = 0;
    send_idle_pct      = 16;
    recv_idle_pct      = 75;
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.range_start = '0;
    req_if.range_end   = '0;
    rsp_if.ready       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_and_reversed();
    test_small_values();
    test_prime_squares();
    test_field_extremes();
    test_output_backpressure();
    test_random_ranges(16, 75);
    test_random_ranges(75, 16);
    test_random_ranges(0, 0);

    // let any stray transaction show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && expected_counts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
